[hdl/snn_pkg.sv]
package snn_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int POS_W      = COL_W + ROW_W;
  localparam int DIV_CNT_W  = $clog2(POS_W);
  localparam int DIST_W     = 18;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  typedef logic [23:0] rgb_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } snn_in_t;

  typedef struct packed {
    logic [7:0]       red_out;
    logic [7:0]       green_out;
    logic [7:0]       blue_out;
    logic [COL_W-1:0] out_column;
    logic [ROW_W-1:0] out_row;
    logic             frame_last;
  } snn_out_t;

  typedef struct packed {
    rgb_t [7:0]       nb;
    rgb_t             ctr;
    logic             interior;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } snn_work_t;

endpackage

[hdl/snn_rgb_filter_3x3.sv]
// channel | direction | handshake            | word
// in      | input     | in_valid / in_ready   | in_data: mode, red_in, green_in, blue_in
// out     | output    | out_valid / out_ready | out_data: rgb, out_column, out_row, frame_last
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data (width, height)
// one word per clock in both directions unless a side stalls; results pass the s1, queue, b1 and output registers
// line stores are read in the cycle a word is taken and written the next, with bypass
// a drain after a width change waits for the serial divider to rebase the position
// reset is synchronous active low; line stores are not cleared, cfg_ready is always high
// output stalls fill the 4-entry queue, then in_ready drops
module snn_rgb_filter_3x3 (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  snn_pkg::snn_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output snn_pkg::snn_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [snn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [snn_pkg::SIZE_W-1:0]     cfg_data
);
  import snn_pkg::*;

  logic              push_valid, head_valid, pop;
  snn_work_t         push_data, head_data;
  logic [QCNT_W-1:0] q_count;

  snn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_count    (q_count),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  snn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .count      (q_count)
  );

  snn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[hdl/snn_front.sv]
module snn_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  snn_pkg::snn_in_t               in_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [snn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [snn_pkg::SIZE_W-1:0]     cfg_data,
  input  logic [snn_pkg::QCNT_W-1:0]     q_count,
  output logic                           push_valid,
  output snn_pkg::snn_work_t             push_data
);
  import snn_pkg::*;

  logic [SIZE_W-1:0]    fw_r, fh_r, w_eff, h_eff, wb_r;
  logic [COL_W-1:0]     x_r, dc_r;
  logic [ROW_W-1:0]     y_r;
  logic                 done_r;
  logic [POS_W-1:0]     dr_r;
  logic                 div_busy_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [POS_W-1:0]     div_q_r;
  logic [SIZE_W-1:0]    div_rem_r;

  rgb_t upper_mem [MAX_WIDTH];
  rgb_t middle_mem [MAX_WIDTH];
  rgb_t up_a_q, up_b_q, mid_q;
  rgb_t up_a_f, up_b_f, mid_f;

  logic             s1_pix_r, s1_push_r, s1_edge_r, s1_interior_r, s1_selmid_r, s1_last_r;
  logic [COL_W-1:0] s1_col_r, s1_addr_r, s1_baddr_r;
  logic [ROW_W-1:0] s1_row_r;
  rgb_t             s1_px_r;

  logic             fwd_en_r;
  logic [COL_W-1:0] fwd_addr_r;
  rgb_t             fwd_up_r, fwd_mid_r;

  rgb_t win_r [3][2];

  logic [SIZE_W-1:0] x_ext, y_ext;
  logic              is_pix, stale, drain_wait, credit_ok, acc, div_start;
  logic              normal, pix_emit, edge_col, interior, last_col, last_row;
  logic              dr_end, d_emit, d_last, selmid;
  logic [COL_W-1:0]  rd_a, rd_b, p_col;
  logic [ROW_W-1:0]  p_row;
  logic [SIZE_W:0]   rem_s;
  logic              div_ge;
  logic [SIZE_W-1:0] rem_nxt;
  logic [POS_W+SIZE_W-1:0] prod;
  rgb_t              px;

  always_comb begin
    if (fw_r == '0) w_eff = SIZE_W'(1);
    else if (fw_r > SIZE_W'(MAX_WIDTH)) w_eff = SIZE_W'(MAX_WIDTH);
    else w_eff = fw_r;
    if (fh_r == '0) h_eff = SIZE_W'(1);
    else if (fh_r > SIZE_W'(MAX_HEIGHT)) h_eff = SIZE_W'(MAX_HEIGHT);
    else h_eff = fh_r;
  end

  assign x_ext  = SIZE_W'(x_r);
  assign y_ext  = SIZE_W'(y_r);
  assign is_pix = !in_data.mode;
  assign px     = {in_data.red_in, in_data.green_in, in_data.blue_in};

  assign stale      = (wb_r != w_eff) || (SIZE_W'(dc_r) >= w_eff);
  assign drain_wait = in_valid && in_data.mode && done_r && stale;
  assign credit_ok  = (q_count + QCNT_W'(s1_push_r)) < QCNT_W'(QDEPTH);
  assign in_ready   = credit_ok && !div_busy_r && !drain_wait;
  assign acc        = in_valid && in_ready;
  assign div_start  = drain_wait && !div_busy_r;
  assign cfg_ready  = 1'b1;

  // pixel side
  assign normal   = x_ext < w_eff;
  assign pix_emit = !done_r && (normal ? ((y_r >= ROW_W'(2)) || (y_r == ROW_W'(1) && x_r != '0))
                                       : ((y_r != '0) || (x_ext >= w_eff + SIZE_W'(1))));
  assign edge_col = x_r == '0;
  assign interior = (y_r >= ROW_W'(2)) && (x_r >= COL_W'(2)) && (x_ext <= w_eff - SIZE_W'(1));
  assign last_col = x_ext >= w_eff - SIZE_W'(1);
  assign last_row = y_ext >= h_eff - SIZE_W'(1);
  assign p_col    = edge_col ? COL_W'(w_eff - SIZE_W'(1)) : x_r - COL_W'(1);
  assign p_row    = edge_col ? y_r - ROW_W'(2) : y_r - ROW_W'(1);

  // drain side
  assign dr_end = dr_r >= POS_W'(h_eff);
  assign d_emit = done_r && !dr_end;
  assign d_last = (dr_r == POS_W'(h_eff - SIZE_W'(1))) && (SIZE_W'(dc_r) == w_eff - SIZE_W'(1));
  assign selmid = dr_r >= POS_W'(h_eff - SIZE_W'(1));

  assign rd_a = is_pix ? x_r : dc_r;
  assign rd_b = COL_W'(w_eff - SIZE_W'(1));

  assign prod    = (POS_W+SIZE_W)'(dr_r) * (POS_W+SIZE_W)'(wb_r);
  assign rem_s   = {div_rem_r, div_q_r[POS_W-1]};
  assign div_ge  = rem_s >= (SIZE_W+1)'(w_eff);
  assign rem_nxt = div_ge ? SIZE_W'(rem_s - (SIZE_W+1)'(w_eff)) : SIZE_W'(rem_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r       <= SIZE_W'(MAX_WIDTH);
      fh_r       <= SIZE_W'(MAX_HEIGHT);
      x_r        <= '0;
      y_r        <= '0;
      done_r     <= 1'b0;
      dr_r       <= '0;
      dc_r       <= '0;
      wb_r       <= SIZE_W'(MAX_WIDTH);
      div_busy_r <= 1'b0;
      div_cnt_r  <= '0;
      s1_pix_r   <= 1'b0;
      s1_push_r  <= 1'b0;
      fwd_en_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  fw_r <= cfg_data;
          CFG_FRAME_HEIGHT: fh_r <= cfg_data;
          default: ;
        endcase
      end
      if (div_start) begin
        div_busy_r <= 1'b1;
        div_cnt_r  <= '0;
        div_q_r    <= prod[POS_W-1:0] + POS_W'(dc_r);
        div_rem_r  <= '0;
      end else if (div_busy_r) begin
        div_q_r   <= {div_q_r[POS_W-2:0], div_ge};
        div_rem_r <= rem_nxt;
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(POS_W - 1)) begin
          div_busy_r <= 1'b0;
          dr_r       <= {div_q_r[POS_W-2:0], div_ge};
          dc_r       <= COL_W'(rem_nxt);
          wb_r       <= w_eff;
        end
      end
      if (acc && is_pix && !done_r) begin
        if (last_col) begin
          x_r <= '0;
          if (last_row) done_r <= 1'b1;
          else y_r <= y_r + ROW_W'(1);
        end else begin
          x_r <= x_r + COL_W'(1);
        end
        if (pix_emit) begin
          wb_r <= w_eff;
          if (y_r != '0) begin
            dr_r <= POS_W'(y_r - ROW_W'(1));
            dc_r <= x_r;
          end else begin
            dr_r <= '0;
            dc_r <= COL_W'(x_ext - w_eff);
          end
        end
      end
      if (acc && !is_pix && done_r) begin
        if (dr_end || d_last) begin
          x_r    <= '0;
          y_r    <= '0;
          done_r <= 1'b0;
          dr_r   <= '0;
          dc_r   <= '0;
          wb_r   <= w_eff;
        end else if (SIZE_W'(dc_r) + SIZE_W'(1) == w_eff) begin
          dc_r <= '0;
          dr_r <= dr_r + POS_W'(1);
        end else begin
          dc_r <= dc_r + COL_W'(1);
        end
      end
      s1_pix_r  <= acc && is_pix && !done_r;
      s1_push_r <= acc && (is_pix ? pix_emit : d_emit);
      fwd_en_r  <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_edge_r     <= edge_col;
    s1_interior_r <= interior;
    s1_selmid_r   <= selmid;
    s1_last_r     <= !is_pix && d_last;
    s1_col_r      <= is_pix ? p_col : dc_r;
    s1_row_r      <= is_pix ? p_row : ROW_W'(dr_r);
    s1_px_r       <= px;
    s1_addr_r     <= rd_a;
    s1_baddr_r    <= rd_b;
    fwd_addr_r    <= s1_addr_r;
    fwd_up_r      <= mid_f;
    fwd_mid_r     <= s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (s1_pix_r) begin
      upper_mem[s1_addr_r]  <= mid_f;
      middle_mem[s1_addr_r] <= s1_px_r;
    end
    up_a_q <= upper_mem[rd_a];
    up_b_q <= upper_mem[rd_b];
    mid_q  <= middle_mem[rd_a];
  end

  assign up_a_f = (fwd_en_r && fwd_addr_r == s1_addr_r)  ? fwd_up_r  : up_a_q;
  assign up_b_f = (fwd_en_r && fwd_addr_r == s1_baddr_r) ? fwd_up_r  : up_b_q;
  assign mid_f  = (fwd_en_r && fwd_addr_r == s1_addr_r)  ? fwd_mid_r : mid_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= '0;
        win_r[r][1] <= '0;
      end
    end else if (s1_pix_r) begin
      for (int r = 0; r < 3; r++) win_r[r][0] <= win_r[r][1];
      win_r[0][1] <= up_a_f;
      win_r[1][1] <= mid_f;
      win_r[2][1] <= s1_px_r;
    end
  end

  always_comb begin
    push_data.nb[0]  = mid_f;
    push_data.nb[1]  = up_a_f;
    push_data.nb[2]  = win_r[0][1];
    push_data.nb[3]  = win_r[0][0];
    push_data.nb[4]  = win_r[1][0];
    push_data.nb[5]  = win_r[2][0];
    push_data.nb[6]  = win_r[2][1];
    push_data.nb[7]  = s1_px_r;
    push_data.col    = s1_col_r;
    push_data.row    = s1_row_r;
    push_data.last   = s1_last_r;
    if (!s1_pix_r) begin
      push_data.ctr      = s1_selmid_r ? mid_f : up_a_f;
      push_data.interior = 1'b0;
    end else if (s1_edge_r) begin
      push_data.ctr      = up_b_f;
      push_data.interior = 1'b0;
    end else begin
      push_data.ctr      = win_r[1][1];
      push_data.interior = s1_interior_r;
    end
  end

  assign push_valid = s1_push_r;

endmodule

[hdl/snn_queue.sv]
module snn_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push_valid,
  input  snn_pkg::snn_work_t          push_data,
  input  logic                        pop,
  output logic                        head_valid,
  output snn_pkg::snn_work_t          head_data,
  output logic [snn_pkg::QCNT_W-1:0]  count
);
  import snn_pkg::*;

  snn_work_t         entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_valid) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_r + QCNT_W'(push_valid) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) entry_r[wr_ptr_r] <= push_data;
  end

  assign head_valid = count_r != '0;
  assign head_data  = entry_r[rd_ptr_r];
  assign count      = count_r;

endmodule

[hdl/snn_back.sv]
module snn_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  input  snn_pkg::snn_work_t  head_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output snn_pkg::snn_out_t   out_data
);
  import snn_pkg::*;

  function automatic logic [DIST_W-1:0] sq_dist(input rgb_t a, input rgb_t b);
    logic [7:0]        d;
    logic [DIST_W-1:0] s;
    s = '0;
    for (int c = 0; c < 3; c++) begin
      d = (a[c*8 +: 8] > b[c*8 +: 8]) ? a[c*8 +: 8] - b[c*8 +: 8] : b[c*8 +: 8] - a[c*8 +: 8];
      s = s + DIST_W'(d) * DIST_W'(d);
    end
    return s;
  endfunction

  logic              b1_valid_r, out_valid_r, en_out, en_b1;
  snn_work_t         b1_work_r;
  logic [DIST_W-1:0] b1_dist_r [8];
  snn_out_t          out_data_r;
  rgb_t              avg;

  assign en_out = !out_valid_r || out_ready;
  assign en_b1  = !b1_valid_r || en_out;
  assign pop    = head_valid && en_b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_b1) b1_valid_r <= head_valid;
      if (en_out) out_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b1) begin
      b1_work_r <= head_data;
      for (int k = 0; k < 8; k++) b1_dist_r[k] <= sq_dist(head_data.nb[k], head_data.ctr);
    end
  end

  always_comb begin
    rgb_t       pick;
    logic [9:0] sum;
    avg = '0;
    for (int c = 0; c < 3; c++) begin
      sum = '0;
      for (int k = 0; k < 4; k++) begin
        pick = (b1_dist_r[k] < b1_dist_r[k+4]) ? b1_work_r.nb[k] : b1_work_r.nb[k+4];
        sum  = sum + 10'(pick[c*8 +: 8]);
      end
      avg[c*8 +: 8] = sum[9:2];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      {out_data_r.red_out, out_data_r.green_out, out_data_r.blue_out} <=
        b1_work_r.interior ? avg : b1_work_r.ctr;
      out_data_r.out_column <= b1_work_r.col;
      out_data_r.out_row    <= b1_work_r.row;
      out_data_r.frame_last <= b1_work_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/snn_chk.sv]
module snn_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input snn_pkg::snn_in_t               in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input snn_pkg::snn_out_t              out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [snn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [snn_pkg::SIZE_W-1:0]     cfg_data
);
  import snn_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("stalled input word changed");

  a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> !$isunknown({cfg_index, cfg_data}))
    else $error("cfg word unknown");

  a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("cfg port blocked");

endmodule

bind snn_rgb_filter_3x3 snn_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

[tb/snn_rgb_filter_3x3_tb.sv]
module snn_rgb_filter_3x3_tb;
  import snn_pkg::*;

  localparam int LIMIT  = 600000;
  localparam int SETTLE = 40;

  typedef struct {
    bit               is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [SIZE_W-1:0] val;
    snn_in_t          word;
    bit               typed;
    snn_out_t         res;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  snn_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  snn_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  snn_rgb_filter_3x3 i_dut (.*);

  // shadow of the filter state
  logic [SIZE_W-1:0] fw_reg = 11'd1024, fh_reg = 11'd1024;
  rgb_t upper_line [MAX_WIDTH];
  rgb_t middle_line [MAX_WIDTH];
  rgb_t win [3][3];
  int unsigned col_in = 0, row_in = 0, out_pos = 0;
  bit done_in = 0;

  snn_out_t pixel_q[$];
  bit typed_has = 0;
  snn_out_t typed_val = '0;
  int errors = 0;
  int cycles = 0;
  int tx_idle_pct = 0, rx_stall_pct = 0;
  int hold_req = 0;
  int hold_cnt = 0;

  initial begin
    for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win[i][j] = '0;
  end

  function automatic int unsigned eff(logic [SIZE_W-1:0] v, int unsigned mx);
    if (v < 1) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic int unsigned dist2(rgb_t a, rgb_t b);
    int unsigned s;
    int d;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      d = int'(a[c*8 +: 8]) - int'(b[c*8 +: 8]);
      s += d * d;
    end
    return s;
  endfunction

  function automatic rgb_t snn_avg();
    int dx[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    int dy[8] = '{0, -1, -1, -1, 0, 1, 1, 1};
    rgb_t nb[8];
    rgb_t ctr, pick, res;
    int unsigned sum;
    ctr = win[1][1];
    res = '0;
    for (int k = 0; k < 8; k++) nb[k] = win[1 + dy[k]][1 + dx[k]];
    for (int c = 0; c < 3; c++) begin
      sum = 0;
      for (int k = 0; k < 4; k++) begin
        pick = dist2(nb[k], ctr) < dist2(nb[k + 4], ctr) ? nb[k] : nb[k + 4];
        sum += pick[c*8 +: 8];
      end
      res[c*8 +: 8] = sum / 4;
    end
    return res;
  endfunction

  function automatic snn_out_t make_res(rgb_t px, int unsigned c, int unsigned r, bit last);
    snn_out_t o;
    o.red_out = px[23:16];
    o.green_out = px[15:8];
    o.blue_out = px[7:0];
    o.out_column = c[COL_W-1:0];
    o.out_row = r[ROW_W-1:0];
    o.frame_last = last;
    return o;
  endfunction

  function automatic void frame_reset();
    col_in = 0;
    row_in = 0;
    out_pos = 0;
    done_in = 0;
  endfunction

  function automatic void store_result(snn_out_t o);
    pixel_q.push_back(typed_has ? typed_val : o);
  endfunction

  function automatic void filter_step(snn_in_t w);
    int unsigned fw, fh, total, p, r, c, idx, p_in, x, y;
    rgb_t px, top, mid, redge, v;
    bit interior;
    fw = eff(fw_reg, MAX_WIDTH);
    fh = eff(fh_reg, MAX_HEIGHT);
    total = fw * fh;
    if (w.mode) begin
      if (!done_in) return;
      p = out_pos;
      if (p >= total) begin
        frame_reset();
        return;
      end
      r = p / fw;
      c = p % fw;
      idx = c % MAX_WIDTH;
      px = (r >= fh - 1) ? middle_line[idx] : upper_line[idx];
      store_result(make_res(px, c, r, p == total - 1));
      if (p == total - 1) frame_reset();
      else out_pos = p + 1;
    end else begin
      if (done_in) return;
      x = col_in;
      y = row_in;
      idx = x % MAX_WIDTH;
      px = {w.red_in, w.green_in, w.blue_in};
      top = upper_line[idx];
      mid = middle_line[idx];
      redge = upper_line[(fw - 1) % MAX_WIDTH];
      p_in = y * fw + x;
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      upper_line[idx] = mid;
      middle_line[idx] = px;
      if (p_in >= fw + 1) begin
        if (x >= 1) begin
          interior = y >= 2 && x >= 2 && x <= fw - 1;
          v = interior ? snn_avg() : win[1][1];
          store_result(make_res(v, x - 1, y - 1, 0));
        end else begin
          store_result(make_res(redge, fw - 1, y - 2, 0));
        end
        out_pos = p_in - fw;
      end
      if (x >= fw - 1) begin
        col_in = 0;
        if (y >= fh - 1) done_in = 1;
        else row_in = y + 1;
      end else begin
        col_in = x + 1;
      end
    end
  endfunction

  // input and config monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_WIDTH) fw_reg = cfg_data;
        else if (cfg_index == CFG_FRAME_HEIGHT) fh_reg = cfg_data;
      end
      if (in_valid && in_ready) filter_step(in_data);
    end
  end

  // result checker
  always @(posedge clk) begin
    snn_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected word: %p", out_data);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (out_data.red_out !== e.red_out) begin
          $error("red_out exp %0d got %0d", e.red_out, out_data.red_out);
          errors++;
        end
        if (out_data.green_out !== e.green_out) begin
          $error("green_out exp %0d got %0d", e.green_out, out_data.green_out);
          errors++;
        end
        if (out_data.blue_out !== e.blue_out) begin
          $error("blue_out exp %0d got %0d", e.blue_out, out_data.blue_out);
          errors++;
        end
        if (out_data.out_column !== e.out_column) begin
          $error("out_column exp %0d got %0d", e.out_column, out_data.out_column);
          errors++;
        end
        if (out_data.out_row !== e.out_row) begin
          $error("out_row exp %0d got %0d", e.out_row, out_data.out_row);
          errors++;
        end
        if (out_data.frame_last !== e.frame_last) begin
          $error("frame_last exp %0d got %0d", e.frame_last, out_data.frame_last);
          errors++;
        end
      end
    end
  end

  // receiver with long hold-off on request
  always @(posedge clk) begin
    if (hold_req != 0 && hold_cnt == 0) hold_cnt <= hold_req;
    if (hold_cnt > 0) begin
      out_ready <= 0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("snn_rgb_filter_3x3 verification failed");
      $finish;
    end
  end

  task automatic send_word(snn_in_t w, bit has, snn_out_t e);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= w;
    typed_has <= has;
    typed_val <= e;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_all();
    in_valid <= 0;
    typed_has <= 0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic snn_in_t pix(logic [23:0] c);
    snn_in_t w;
    w.mode = 0;
    {w.red_in, w.green_in, w.blue_in} = c;
    return w;
  endfunction

  function automatic snn_in_t rand_pix();
    logic [23:0] pal[4] = '{24'h102030, 24'h112131, 24'h0f1f2f, 24'h203040};
    case ($urandom_range(3))
      0: return pix(pal[$urandom_range(3)]);
      1: return pix({{8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                     {8{1'($urandom_range(1))}}});
      default: return pix(24'($urandom));
    endcase
  endfunction

  function automatic snn_in_t drain_word();
    snn_in_t w;
    w = snn_in_t'($urandom);
    w.mode = 1;
    return w;
  endfunction

  // one frame, with stray drains inside and stray pixels during the flush
  task automatic run_frame(int unsigned fw, int unsigned fh, bit noise);
    for (int unsigned i = 0; i < fw * fh; i++) begin
      if (noise && $urandom_range(99) < 4) send_word(drain_word(), 0, '0);
      send_word(rand_pix(), 0, '0);
    end
    for (int unsigned i = 0; i < fw + 3; i++) begin
      if (noise && $urandom_range(99) < 10) send_word(rand_pix(), 0, '0);
      send_word(drain_word(), 0, '0);
    end
  endtask

  task automatic set_size(logic [SIZE_W-1:0] fw, logic [SIZE_W-1:0] fh);
    drain_all();
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] v);
    stim_row_t s;
    s = '{1, idx, v, '0, 0, '0};
    return s;
  endfunction

  function automatic stim_row_t item_row(snn_in_t w, bit typed, snn_out_t e);
    stim_row_t s;
    s = '{0, '0, '0, w, typed, e};
    return s;
  endfunction

  initial begin
    int unsigned fw, fh;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single pixel frames, then a 3x3 frame
    dir_rows.push_back(cfg_row(CFG_FRAME_WIDTH, 11'd1));
    dir_rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 11'd1));
    dir_rows.push_back(item_row(pix(24'hff00aa), 0, '0));
    dir_rows.push_back(item_row(drain_word(), 1, make_res(24'hff00aa, 0, 0, 1)));
    dir_rows.push_back(item_row(pix(24'h00ff55), 0, '0));
    dir_rows.push_back(item_row(drain_word(), 1, make_res(24'h00ff55, 0, 0, 1)));
    dir_rows.push_back(item_row(drain_word(), 0, '0));
    dir_rows.push_back(cfg_row(CFG_FRAME_WIDTH, 11'd3));
    dir_rows.push_back(cfg_row(CFG_FRAME_HEIGHT, 11'd3));
    dir_rows.push_back(item_row(drain_word(), 0, '0));
    dir_rows.push_back(item_row(pix(24'h000000), 0, '0));
    dir_rows.push_back(item_row(pix(24'hffffff), 0, '0));
    dir_rows.push_back(item_row(pix(24'h102030), 0, '0));
    dir_rows.push_back(item_row(pix(24'h0f1f2f), 0, '0));
    dir_rows.push_back(item_row(pix(24'h80ff01), 0, '0));
    dir_rows.push_back(item_row(pix(24'h112131), 0, '0));
    dir_rows.push_back(item_row(pix(24'hffffff), 0, '0));
    dir_rows.push_back(item_row(pix(24'h000000), 0, '0));
    dir_rows.push_back(item_row(pix(24'h7f7f7f), 0, '0));
    dir_rows.push_back(item_row(pix(24'h123456), 0, '0));
    for (int i = 0; i < 5; i++) dir_rows.push_back(item_row(drain_word(), 0, '0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain_all();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // height shrunk mid-frame
    set_size(11'd5, 11'd6);
    for (int i = 0; i < 12; i++) send_word(rand_pix(), 0, '0);
    drain_all();
    write_reg(CFG_FRAME_HEIGHT, 11'd2);
    for (int i = 0; i < 6; i++) send_word(rand_pix(), 0, '0);
    for (int i = 0; i < 8; i++) send_word(drain_word(), 0, '0);

    // saturated sizes, the large ones cut short by a smaller size
    set_size(11'd0, 11'd0);
    run_frame(1, 1, 0);
    set_size(11'd2047, 11'd1);
    for (int i = 0; i < 3; i++) send_word(rand_pix(), 0, '0);
    drain_all();
    write_reg(CFG_FRAME_WIDTH, 11'd4);
    send_word(rand_pix(), 0, '0);
    for (int i = 0; i < 6; i++) send_word(drain_word(), 0, '0);
    set_size(11'd1, 11'd2047);
    for (int i = 0; i < 4; i++) send_word(rand_pix(), 0, '0);
    drain_all();
    write_reg(CFG_FRAME_HEIGHT, 11'd5);
    send_word(rand_pix(), 0, '0);
    for (int i = 0; i < 6; i++) send_word(drain_word(), 0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
        default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
      endcase
      for (int f = 0; f < 5; f++) begin
        fw = (f == 0) ? 1 : (ph == 0 && f == 2) ? 8 : $urandom_range(1, 8);
        fh = (f == 1) ? 1 : (ph == 0 && f == 2) ? 5 : $urandom_range(1, 5);
        set_size(fw[SIZE_W-1:0], fh[SIZE_W-1:0]);
        if (ph == 0 && f == 2) hold_req <= 60;
        run_frame(fw, fh, 1);
        hold_req <= 0;
      end
    end

    drain_all();
    if (errors == 0) begin
      $display("snn_rgb_filter_3x3 verification clean");
    end else begin
      $display("snn_rgb_filter_3x3 verification failed");
    end
    $finish;
  end

endmodule
